>>> design/pidcd_pkg.sv
// Shared widths, register indexes, configuration type and saturation helper for the PID block.
`default_nettype none
package pidcd_pkg;

	localparam int DATA_W    = 16;
	localparam int GAIN_W    = 16;
	localparam int ERR_W     = 17;
	localparam int DIFF_W    = 19;
	localparam int PROD_W    = 35;
	localparam int ACC_W     = 48;
	localparam int SUM_W     = 50;
	localparam int DRIVE_W   = 32;
	localparam int IDX_W     = 3;
	localparam int CFG_W     = 16;
	localparam int GAIN_FRAC = 8;

	// Register indexes on the configuration channel
	localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_P  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_I  = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_D  = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd4;
	localparam logic [IDX_W-1:0] REG_OUT_MAX = 3'd5;

	localparam logic [CFG_W-1:0] OUT_MAX_RESET = 16'd1000;

	// Accumulator range, extended to the width of an unsaturated sum
	localparam logic signed [SUM_W-1:0] SUM_ACC_MAX =
		{{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_ACC_MIN = ~SUM_ACC_MAX;

	// Drive range, extended to accumulator width
	localparam logic signed [ACC_W-1:0] ACC_DRIVE_MAX =
		{{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_DRIVE_MIN = ~ACC_DRIVE_MAX;

	typedef struct packed {
		logic                     mode_incremental;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic                     limit_enable;
		logic [CFG_W-1:0]         out_max;
	} cfg_t;

	// Hold a wide sum at the ends of the signed accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > SUM_ACC_MAX) begin
			r = SUM_ACC_MAX[ACC_W-1:0];
		end else if (v < SUM_ACC_MIN) begin
			r = SUM_ACC_MIN[ACC_W-1:0];
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/pidcd_cfg.sv
// Configuration register file of the PID block.
`default_nettype none
module pidcd_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pidcd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [pidcd_pkg::CFG_W-1:0]   cfg_data,
	output pidcd_pkg::cfg_t                    cfg
);
	import pidcd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Write the addressed register on a transfer; drop indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_incremental <= 1'b1;
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.limit_enable     <= 1'b1;
			cfg_q.out_max          <= OUT_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:    cfg_q.mode_incremental <= cfg_data[0];
				REG_GAIN_P:  cfg_q.gain_p           <= $signed(cfg_data);
				REG_GAIN_I:  cfg_q.gain_i           <= $signed(cfg_data);
				REG_GAIN_D:  cfg_q.gain_d           <= $signed(cfg_data);
				REG_LIMIT:   cfg_q.limit_enable     <= cfg_data[0];
				REG_OUT_MAX: cfg_q.out_max          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/pidcd_core.sv
// Control law datapath: error history, integral and output accumulators, clamp and drive.
`default_nettype none
module pidcd_core #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pidcd_pkg::cfg_t                     cfg,
	input  wire logic                                step,
	input  wire logic signed [pidcd_pkg::DATA_W-1:0] setpoint,
	input  wire logic signed [pidcd_pkg::DATA_W-1:0] measured,
	output logic signed [pidcd_pkg::DRIVE_W-1:0]     drive
);
	import pidcd_pkg::*;

	localparam int SHL = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
	localparam int SHR = (FRAC_BITS <  GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;

	logic signed [ERR_W-1:0]  err_last_q, err_before_last_q;
	logic signed [ACC_W-1:0]  integral_sum_q, output_acc_q;

	logic signed [ERR_W-1:0]  e0;
	logic signed [DIFF_W-1:0] e0_x, e1_x, e2_x, diff1, diff2, opnd_p, opnd_d;
	logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
	logic signed [ACC_W-1:0]  term_p, term_i, term_d;
	logic signed [SUM_W-1:0]  sum_inc, sum_int, sum_pos;
	logic signed [ACC_W-1:0]  integral_next, law_acc, acc_next, top, acc_int;

	// Error and its differences
	assign e0    = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
	assign e0_x  = DIFF_W'(e0);
	assign e1_x  = DIFF_W'(err_last_q);
	assign e2_x  = DIFF_W'(err_before_last_q);
	assign diff1 = e0_x - e1_x;
	assign diff2 = e0_x - (e1_x <<< 1) + e2_x;

	// Select multiplier operands for the active law
	assign opnd_p = cfg.mode_incremental ? diff1 : e0_x;
	assign opnd_d = cfg.mode_incremental ? diff2 : diff1;

	// Three gain products, rescaled to accumulator fraction bits (floor on right shift)
	assign prod_p = PROD_W'(cfg.gain_p) * PROD_W'(opnd_p);
	assign prod_i = PROD_W'(cfg.gain_i) * PROD_W'(e0_x);
	assign prod_d = PROD_W'(cfg.gain_d) * PROD_W'(opnd_d);
	assign term_p = (ACC_W'(prod_p) <<< SHL) >>> SHR;
	assign term_i = (ACC_W'(prod_i) <<< SHL) >>> SHR;
	assign term_d = (ACC_W'(prod_d) <<< SHL) >>> SHR;

	// Incremental and positional laws
	assign sum_inc = SUM_W'(output_acc_q) + SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
	assign sum_int = SUM_W'(integral_sum_q) + SUM_W'(term_i);
	assign integral_next = sat_acc(sum_int);
	assign sum_pos = SUM_W'(term_p) + SUM_W'(integral_next) + SUM_W'(term_d);
	assign law_acc = cfg.mode_incremental ? sat_acc(sum_inc) : sat_acc(sum_pos);

	// Clamp to zero through the maximum when enabled
	assign top = $signed({{(ACC_W-CFG_W){1'b0}}, cfg.out_max}) <<< FRAC_BITS;
	always_comb begin
		acc_next = law_acc;
		if (cfg.limit_enable) begin
			if (acc_next >= top) begin
				acc_next = top;
			end
			if (acc_next <= ACC_W'(0)) begin
				acc_next = '0;
			end
		end
	end

	// Integer part, saturated to the drive width
	assign acc_int = acc_next >>> FRAC_BITS;
	always_comb begin
		if (acc_int > ACC_DRIVE_MAX) begin
			drive = ACC_DRIVE_MAX[DRIVE_W-1:0];
		end else if (acc_int < ACC_DRIVE_MIN) begin
			drive = ACC_DRIVE_MIN[DRIVE_W-1:0];
		end else begin
			drive = acc_int[DRIVE_W-1:0];
		end
	end

	// Advance controller state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_last_q        <= '0;
			err_before_last_q <= '0;
			integral_sum_q    <= '0;
			output_acc_q      <= '0;
		end else if (step) begin
			err_before_last_q <= err_last_q;
			err_last_q        <= e0;
			output_acc_q      <= acc_next;
			if (!cfg.mode_incremental) begin
				integral_sum_q <= integral_next;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/pid_controller_dual_mode.sv
// Dual-mode PID controller: top level with input stage, output register and config port.
// Usage:
//   Input channel in_valid/in_ready carries one setpoint and measured pair per
//   control tick. Output channel out_valid/out_ready returns one drive value per
//   input transfer, in order. The cfg channel writes one register per transfer
//   (index 0 mode, 1..3 gains P/I/D, 4 limit enable, 5 out_max); cfg_ready is
//   always high, and writes belong in idle periods between items.
//   Flow: an input transfer lands in the input stage; its result is loaded into
//   the output register once that is free or draining, and offered from then on.
//   Throughput: one item per cycle while out_ready is high. The error history and
//   accumulators update as an item leaves the input stage, so the law closes its
//   feedback loop without a pipeline gap and items follow back to back.
//   Reset: arst_n clears the error history, integral and output accumulator,
//   loads the register defaults (incremental mode, zero gains, clamp on, max 1000)
//   and empties both stages.
//   Stall: while out_ready is low the output register holds its value, the input
//   stage holds one more item, and in_ready drops once both are full.
`default_nettype none
module pid_controller_dual_mode #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [pidcd_pkg::DATA_W-1:0] setpoint,
	input  wire logic signed [pidcd_pkg::DATA_W-1:0] measured,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [pidcd_pkg::DRIVE_W-1:0]     drive,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pidcd_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [pidcd_pkg::CFG_W-1:0]         cfg_data
);
	import pidcd_pkg::*;

	cfg_t                     cfg;
	logic                     valid_s1;
	logic signed [DATA_W-1:0] setpoint_s1, measured_s1;
	logic                     out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q, drive_next;
	logic                     advance;

	pidcd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidcd_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (advance),
		.setpoint (setpoint_s1),
		.measured (measured_s1),
		.drive    (drive_next)
	);

	// Move the staged item into the output register when it is free or draining
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_next;
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for the dual-mode PID controller: queued control ticks, fixed-point predictor, drive checks.
`timescale 1ns / 100ps
module tb;
	import pidcd_pkg::*;

	localparam int FRAC = 8;
	localparam int WIND_TICKS = 300;
	localparam longint ACC_TOP = 64'sh7FFF_FFFF_FFFF;
	localparam longint ACC_BOT = -ACC_TOP - 1;
	localparam longint DRIVE_TOP = 64'sd2147483647;
	localparam longint DRIVE_BOT = -DRIVE_TOP - 1;
	// Indexes past the register list; writes there must change nothing
	localparam logic [IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNUSED_B = 3'd7;

	typedef struct packed {
		logic signed [DATA_W-1:0] sp;
		logic signed [DATA_W-1:0] ms;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DATA_W-1:0] setpoint = '0;
	logic signed [DATA_W-1:0] measured = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Predictor copy of the registers
	logic law_incr = 1'b1;
	logic signed [GAIN_W-1:0] kp = '0;
	logic signed [GAIN_W-1:0] ki = '0;
	logic signed [GAIN_W-1:0] kd = '0;
	logic clamp_on = 1'b1;
	logic [CFG_W-1:0] drive_cap = OUT_MAX_RESET;

	// Predictor copy of the controller state
	logic signed [ERR_W-1:0] e_last = '0;
	logic signed [ERR_W-1:0] e_prev = '0;
	logic signed [ACC_W-1:0] integ = '0;
	logic signed [ACC_W-1:0] acc = '0;

	tick_t ticks[$];
	logic signed [DRIVE_W-1:0] drive_due[$];
	int ticks_total = 0;
	int ticks_taken = 0;
	int mismatches = 0;
	int in_idle = 0;
	int out_idle = 0;
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;

	pid_controller_dual_mode #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint(setpoint),
		.measured(measured),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gain times error, moved from the gain's fraction to the accumulator's
	function automatic longint scaled(input logic signed [GAIN_W-1:0] gain, input longint e);
		longint prod;
		prod = longint'(gain) * e;
		if (FRAC >= GAIN_FRAC) begin
			return prod <<< (FRAC - GAIN_FRAC);
		end
		return prod >>> (GAIN_FRAC - FRAC);
	endfunction

	function automatic longint sat48(input longint v);
		if (v > ACC_TOP) begin
			return ACC_TOP;
		end
		if (v < ACC_BOT) begin
			return ACC_BOT;
		end
		return v;
	endfunction

	// Advance the controller by one tick and return the drive it produces
	function automatic logic signed [DRIVE_W-1:0] predict_drive(
		input logic signed [DATA_W-1:0] sp, input logic signed [DATA_W-1:0] ms);
		longint e0, e1, e2, a, top, d;
		e0 = longint'(sp) - longint'(ms);
		e1 = e_last;
		e2 = e_prev;
		if (law_incr) begin
			a = sat48(acc + scaled(kp, e0 - e1) + scaled(ki, e0)
				+ scaled(kd, e0 - 2 * e1 + e2));
		end else begin
			integ = ACC_W'(sat48(integ + scaled(ki, e0)));
			a = sat48(scaled(kp, e0) + integ + scaled(kd, e0 - e1));
		end
		if (clamp_on) begin
			top = longint'(drive_cap) << FRAC;
			if (a >= top) begin
				a = top;
			end
			if (a <= 0) begin
				a = 0;
			end
		end
		acc = ACC_W'(a);
		e_prev = e_last;
		e_last = e0[ERR_W-1:0];
		d = a >>> FRAC;
		if (d > DRIVE_TOP) begin
			d = DRIVE_TOP;
		end
		if (d < DRIVE_BOT) begin
			d = DRIVE_BOT;
		end
		return d[DRIVE_W-1:0];
	endfunction

	// Cycles to idle before the next transfer: none, any, or mostly none
	function automatic int unsigned idle_draw(input int style);
		case (style)
			0: return 0;
			1: return $urandom_range(0, 17);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		endcase
	endfunction

	// Feed queued ticks, with a drawn gap after each transfer
	always @(posedge clk) begin : tick_feed
		tick_t t;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				drive_due.push_back(predict_drive(setpoint, measured));
				ticks_taken++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (ticks.size() != 0) begin
					t = ticks.pop_front();
					setpoint <= t.sp;
					measured <= t.ms;
					in_valid <= 1'b1;
					in_gap <= idle_draw(in_idle);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each drive transfer against the oldest prediction, then stall at random
	always @(posedge clk) begin : drive_check
		logic signed [DRIVE_W-1:0] want;
		int unsigned s;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			s = out_stall;
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("drive %0d arrived with nothing pending", drive);
					end
				end else begin
					want = drive_due.pop_front();
					if (drive !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("drive: expected %0d, got %0d", want, drive);
						end
					end
				end
				s = idle_draw(out_idle);
			end
			if (s != 0) begin
				out_ready <= 1'b0;
				out_stall <= s - 1;
			end else begin
				out_ready <= 1'b1;
				out_stall <= 0;
			end
		end
	end

	// One register write; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE: law_incr = val[0];
			REG_GAIN_P: kp = val;
			REG_GAIN_I: ki = val;
			REG_GAIN_D: kd = val;
			REG_LIMIT: clamp_on = val[0];
			REG_OUT_MAX: drive_cap = val;
			default: ;
		endcase
	endtask

	task automatic queue_tick(input logic signed [DATA_W-1:0] sp,
		input logic signed [DATA_W-1:0] ms);
		ticks.push_back({sp, ms});
		ticks_total++;
	endtask

	// Mostly a measurement near the setpoint, sometimes anything
	task automatic queue_random_tick();
		logic signed [DATA_W-1:0] sp;
		sp = 16'($urandom);
		if ($urandom_range(0, 9) < 7) begin
			queue_tick(sp, sp + 16'($urandom_range(0, 600) - 300));
		end else begin
			queue_tick(sp, 16'($urandom));
		end
	endtask

	// Wait until every tick is taken and every drive has come back
	task automatic wait_drained();
		do @(posedge clk); while (ticks_taken != ticks_total || drive_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_cap();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return OUT_MAX_RESET;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic shuffle_setup();
		write_reg(REG_MODE, 16'($urandom));
		write_reg(REG_GAIN_P, pick_gain());
		write_reg(REG_GAIN_I, pick_gain());
		write_reg(REG_GAIN_D, pick_gain());
		write_reg(REG_LIMIT, 16'($urandom));
		write_reg(REG_OUT_MAX, pick_cap());
		write_reg(REG_UNUSED_A + 3'($urandom_range(0, 1)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin : scenario
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		in_idle = 1;
		out_idle = 1;

		// Reset defaults: zero gains, so every drive is zero
		queue_tick(16'sh0000, 16'sh0000);
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh8000, 16'sh7FFF);
		queue_tick(16'shFFFF, 16'shFFFF);
		wait_drained();

		// Incremental law against the default clamp, plus ignored indexes
		write_reg(REG_GAIN_P, 16'sd256);
		write_reg(REG_GAIN_I, 16'sd128);
		write_reg(REG_GAIN_D, -16'sd256);
		write_reg(REG_UNUSED_A, 16'hFFFF);
		write_reg(REG_UNUSED_B, 16'h1234);
		cfg_valid <= 1'b0;
		queue_tick(16'sd500, 16'sd0);
		queue_tick(16'sd500, 16'sd0);
		queue_tick(16'sd2000, 16'sd0);
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh8000, 16'sh7FFF);
		queue_tick(16'sd0, 16'sd0);
		wait_drained();

		// Positional law at extreme gains, clamp off (upper data bits set)
		write_reg(REG_MODE, 16'hFFFE);
		write_reg(REG_GAIN_P, 16'h7FFF);
		write_reg(REG_GAIN_I, 16'h8000);
		write_reg(REG_GAIN_D, 16'h7FFF);
		write_reg(REG_LIMIT, 16'hFFFE);
		cfg_valid <= 1'b0;
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh8000, 16'sh7FFF);
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sd0, 16'sd0);
		queue_tick(16'sd12345, -16'sd321);
		wait_drained();

		// Clamp at both ends of the output range
		write_reg(REG_MODE, 16'h0001);
		write_reg(REG_LIMIT, 16'h0001);
		write_reg(REG_OUT_MAX, 16'h0000);
		cfg_valid <= 1'b0;
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh8000, 16'sh7FFF);
		queue_tick(16'sd100, 16'sd0);
		wait_drained();
		write_reg(REG_OUT_MAX, 16'hFFFF);
		cfg_valid <= 1'b0;
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh7FFF, 16'sh8000);
		queue_tick(16'sh8000, 16'sh7FFF);
		wait_drained();

		// Random settings, each with its own idling style
		repeat (8) begin
			shuffle_setup();
			in_idle = $urandom_range(0, 2);
			out_idle = $urandom_range(0, 2);
			repeat (160) queue_random_tick();
			wait_drained();
		end

		// Wind the output accumulator up until the drive saturates high, clamp off
		in_idle = 0;
		out_idle = 0;
		write_reg(REG_MODE, 16'h0001);
		write_reg(REG_GAIN_P, 16'h0000);
		write_reg(REG_GAIN_I, 16'h7FFF);
		write_reg(REG_GAIN_D, 16'h0000);
		write_reg(REG_LIMIT, 16'h0000);
		cfg_valid <= 1'b0;
		repeat (WIND_TICKS) queue_tick(16'sh7FFF, 16'sh8000);
		wait_drained();

		// Wind the integral down until the drive saturates low, positional law
		write_reg(REG_MODE, 16'h0000);
		write_reg(REG_GAIN_P, 16'h8000);
		write_reg(REG_GAIN_I, 16'h8000);
		write_reg(REG_GAIN_D, 16'h8000);
		cfg_valid <= 1'b0;
		repeat (WIND_TICKS) queue_tick(16'sh7FFF, 16'sh8000);
		wait_drained();

		// Leave saturation through the clamp
		in_idle = 2;
		out_idle = 2;
		write_reg(REG_MODE, 16'h0001);
		write_reg(REG_LIMIT, 16'h0001);
		write_reg(REG_OUT_MAX, 16'hFFFF);
		cfg_valid <= 1'b0;
		repeat (12) queue_random_tick();
		wait_drained();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && drive_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
